// ===== hdl/nfcs_pkg.sv =====
// Package for the NOR flash command sequencer: request and result types,
// command, operation and bus cycle codes, and the flash command constants.
// No dependencies.
package nfcs_pkg;

  // Request codes as they arrive on the input.
  localparam logic [1:0] CMD_READ    = 2'd0;
  localparam logic [1:0] CMD_PROGRAM = 2'd1;
  localparam logic [1:0] CMD_ERASE   = 2'd2;
  localparam logic [1:0] CMD_RESET   = 2'd3;

  // Classified operations handed from the front end to the back end.
  localparam logic [2:0] OP_READ    = 3'd0;
  localparam logic [2:0] OP_PROGRAM = 3'd1;
  localparam logic [2:0] OP_ERASE   = 3'd2;
  localparam logic [2:0] OP_RESET   = 3'd3;
  localparam logic [2:0] OP_REJECT  = 3'd4;

  // Bus cycle kinds on the result.
  localparam logic [1:0] KIND_READ   = 2'd0;
  localparam logic [1:0] KIND_WRITE  = 2'd1;
  localparam logic [1:0] KIND_RESET  = 2'd2;
  localparam logic [1:0] KIND_REJECT = 2'd3;

  // Width of the address that reaches the pins (A-1 up to A20).
  localparam int PIN_ADDR_W = 22;

  // Unlock and command constants of the command set.
  localparam logic [PIN_ADDR_W-1:0] UNLOCK_ADDR_A = 22'h000AAA;
  localparam logic [PIN_ADDR_W-1:0] UNLOCK_ADDR_B = 22'h000555;
  localparam logic [7:0] UNLOCK_DATA_A = 8'hAA;
  localparam logic [7:0] UNLOCK_DATA_B = 8'h55;
  localparam logic [7:0] PROGRAM_CODE  = 8'hA0;
  localparam logic [7:0] ERASE_SETUP   = 8'h80;
  localparam logic [7:0] ERASE_CHIP    = 8'h10;

  // Default limits and queue depth.
  localparam int DEFAULT_PROGRAM_LIMIT = 32'h0040_0000;
  localparam int DEFAULT_ACCESS_LIMIT  = 32'h0400_0000;
  localparam int DEFAULT_QUEUE_DEPTH   = 4;

  // One flash request.
  typedef struct packed {
    logic [1:0]  cmd;
    logic [25:0] address;
    logic [7:0]  data_byte;
  } req_item_t;

  // One bus cycle, or a rejection.
  typedef struct packed {
    logic [1:0] cycle_kind;
    logic       addr_bit_minus1;
    logic [7:0] addr_low;
    logic [7:0] addr_mid;
    logic [4:0] addr_high;
    logic [7:0] bus_data;
    logic       last;
  } res_item_t;

  // Classified operation between front end and back end.
  typedef struct packed {
    logic [2:0]            op;
    logic [PIN_ADDR_W-1:0] addr;
    logic [7:0]            data;
  } seq_op_t;

endpackage

// ===== hdl/nfcs_front.sv =====
// Front end of the NOR flash command sequencer: accepts requests, checks
// the address limits and registers the classified operation.
// Depends on nfcs_pkg.
module nfcs_front import nfcs_pkg::*; #(
  parameter int PROGRAM_LIMIT = DEFAULT_PROGRAM_LIMIT,
  parameter int ACCESS_LIMIT  = DEFAULT_ACCESS_LIMIT
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  output logic      full,
  input  req_item_t req,
  output logic      op_valid,
  input  logic      op_ready,
  output seq_op_t   op_item
);

  localparam logic [26:0] PROG_LIM = 27'(PROGRAM_LIMIT);
  localparam logic [26:0] ACC_LIM  = 27'(ACCESS_LIMIT);

  logic        load;
  logic [26:0] addr_ext;
  seq_op_t     op_next;

  // The stage takes a new transaction when it is empty or being drained.
  assign load = !op_valid || op_ready;
  assign full = !load;

  // Classify the request against the limits.
  always_comb begin
    addr_ext     = {1'b0, req.address};
    op_next.addr = req.address[PIN_ADDR_W-1:0];
    op_next.data = req.data_byte;
    case (req.cmd)
      CMD_READ: begin
        op_next.op = (addr_ext >= ACC_LIM) ? OP_REJECT : OP_READ;
      end
      CMD_PROGRAM: begin
        op_next.op = (addr_ext >= PROG_LIM || addr_ext >= ACC_LIM) ? OP_REJECT : OP_PROGRAM;
      end
      CMD_ERASE: begin
        op_next.op = OP_ERASE;
      end
      default: begin
        op_next.op = OP_RESET;
      end
    endcase
  end

  // Output register of the front end.
  always_ff @(posedge clk) begin
    if (rst) begin
      op_valid <= 1'b0;
    end else if (load) begin
      op_valid <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (load && push) begin
      op_item <= op_next;
    end
  end

endmodule

// ===== hdl/nfcs_queue.sv =====
// Short queue of classified operations between the front and back ends.
// Depends on nfcs_pkg.
module nfcs_queue import nfcs_pkg::*; #(
  parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  seq_op_t in_item,
  output logic    out_valid,
  input  logic    out_ready,
  output seq_op_t out_item
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  seq_op_t          mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W-1:0] rd_ptr_next;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign in_ready  = (count != FULL_CNT);
  assign out_valid = (count != '0);
  assign do_wr     = in_valid && in_ready;
  assign do_rd     = out_valid && out_ready;

  // Read pointer for the coming cycle.
  always_comb begin
    if (rst) begin
      rd_ptr_next = '0;
    end else if (do_rd) begin
      rd_ptr_next = (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
    end else begin
      rd_ptr_next = rd_ptr;
    end
  end

  // Storage write.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= in_item;
    end
  end

  // Registered read of the oldest entry; a write to that entry is passed straight through.
  always_ff @(posedge clk) begin
    if (do_wr && (wr_ptr == rd_ptr_next)) begin
      out_item <= in_item;
    end else begin
      out_item <= mem[rd_ptr_next];
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      rd_ptr <= rd_ptr_next;
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/nfcs_back.sv =====
// Back end of the NOR flash command sequencer: steps through the bus cycles
// of each operation and holds the current cycle in the result register.
// Depends on nfcs_pkg.
module nfcs_back import nfcs_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      op_valid,
  output logic      op_ready,
  input  seq_op_t   op_item,
  output logic      empty,
  input  logic      pop,
  output res_item_t result
);

  logic                  cur_valid;
  seq_op_t               cur;
  logic [2:0]            step;
  logic                  res_valid;
  logic                  adv;
  logic                  step_last;
  logic                  load;
  logic [1:0]            kind;
  logic [PIN_ADDR_W-1:0] addr;
  logic [7:0]            data;
  res_item_t             res_next;

  // A bus cycle is produced when the result register is free or being taken.
  assign adv      = cur_valid && (!res_valid || pop);
  assign load     = !cur_valid || (adv && step_last);
  assign op_ready = load;
  assign empty    = !res_valid;

  // Bus cycle of the current operation at the current step.
  always_comb begin
    kind      = KIND_WRITE;
    addr      = '0;
    data      = '0;
    step_last = 1'b1;
    case (cur.op)
      OP_READ: begin
        kind = KIND_READ;
        addr = cur.addr;
      end
      OP_PROGRAM: begin
        step_last = (step == 3'd3);
        case (step)
          3'd0: begin
            addr = UNLOCK_ADDR_A;
            data = UNLOCK_DATA_A;
          end
          3'd1: begin
            addr = UNLOCK_ADDR_B;
            data = UNLOCK_DATA_B;
          end
          3'd2: begin
            addr = UNLOCK_ADDR_A;
            data = PROGRAM_CODE;
          end
          default: begin
            addr = cur.addr;
            data = cur.data;
          end
        endcase
      end
      OP_ERASE: begin
        step_last = (step == 3'd5);
        case (step)
          3'd0, 3'd3: begin
            addr = UNLOCK_ADDR_A;
            data = UNLOCK_DATA_A;
          end
          3'd1, 3'd4: begin
            addr = UNLOCK_ADDR_B;
            data = UNLOCK_DATA_B;
          end
          3'd2: begin
            addr = UNLOCK_ADDR_A;
            data = ERASE_SETUP;
          end
          default: begin
            addr = UNLOCK_ADDR_A;
            data = ERASE_CHIP;
          end
        endcase
      end
      OP_RESET: begin
        kind = KIND_RESET;
      end
      default: begin
        kind = KIND_REJECT;
      end
    endcase
    res_next.cycle_kind      = kind;
    res_next.addr_bit_minus1 = addr[0];
    res_next.addr_low        = addr[8:1];
    res_next.addr_mid        = addr[16:9];
    res_next.addr_high       = addr[21:17];
    res_next.bus_data        = data;
    res_next.last            = step_last;
  end

  // Current operation and step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      step      <= '0;
    end else if (load) begin
      cur_valid <= op_valid;
      step      <= '0;
    end else if (adv) begin
      step <= step + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load && op_valid) begin
      cur <= op_item;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= 1'b1;
    end else if (pop) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result <= res_next;
    end
  end

endmodule

// ===== hdl/nor_flash_command_sequencer.sv =====
// Top level of the NOR flash command sequencer: front end, operation queue
// and bus cycle back end. Depends on nfcs_pkg, nfcs_front, nfcs_queue, nfcs_back.
//
//   channel   handshake        payload      direction
//   request   push / full      req_item_t   in
//   result    pop / empty      res_item_t   out
//
// One result transaction leaves per clock when pop is held and operations are waiting:
// a read, reset or rejected request gives one result, a program four, a chip erase six,
// set by the back end's step counter producing one bus cycle per clock unless stalled.
// An accepted request passes the front register, the queue and the back end's registers.
// Reset clears the front register, the queue count and the back end.
// A stalled result holds the back end; requests keep entering until the queue fills.
module nor_flash_command_sequencer import nfcs_pkg::*; #(
  parameter int PROGRAM_LIMIT = DEFAULT_PROGRAM_LIMIT,
  parameter int ACCESS_LIMIT  = DEFAULT_ACCESS_LIMIT,
  parameter int QUEUE_DEPTH   = DEFAULT_QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  output logic      full,
  input  req_item_t req,
  output logic      empty,
  input  logic      pop,
  output res_item_t result
);

  logic    fe_valid;
  logic    fe_ready;
  seq_op_t fe_item;
  logic    q_valid;
  logic    q_ready;
  seq_op_t q_item;

  // Request classification.
  nfcs_front #(
    .PROGRAM_LIMIT(PROGRAM_LIMIT),
    .ACCESS_LIMIT (ACCESS_LIMIT)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .req     (req),
    .op_valid(fe_valid),
    .op_ready(fe_ready),
    .op_item (fe_item)
  );

  // Decoupling queue.
  nfcs_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .in_valid (fe_valid),
    .in_ready (fe_ready),
    .in_item  (fe_item),
    .out_valid(q_valid),
    .out_ready(q_ready),
    .out_item (q_item)
  );

  // Bus cycle sequencing.
  nfcs_back u_back (
    .clk     (clk),
    .rst     (rst),
    .op_valid(q_valid),
    .op_ready(q_ready),
    .op_item (q_item),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

endmodule

// ===== tb/nfcs_bus_checker.sv =====
// Bus cycle checker for the NOR flash command sequencer testbench.
// Predicts the bus cycles of every accepted request and compares each popped result with them.
// Depends on nfcs_pkg.
`timescale 1ns / 1ps

module nfcs_bus_checker import nfcs_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  logic      full,
  input  req_item_t req,
  input  logic      empty,
  input  logic      pop,
  input  res_item_t result,
  output int        fail_count,
  output int        outstanding,
  output int        requests_seen,
  output int        rejects_seen,
  output int        cycles_checked
);

  // Bus cycles still owed by the block, oldest first.
  res_item_t expected_cycles[$];

  // Build one bus cycle with the pin address split onto its pin groups.
  function automatic res_item_t bus_cycle(logic [1:0] kind, logic [PIN_ADDR_W-1:0] pins,
                                          logic [7:0] data, logic last);
    res_item_t c;
    c.cycle_kind      = kind;
    c.addr_bit_minus1 = pins[0];
    c.addr_low        = pins[8:1];
    c.addr_mid        = pins[16:9];
    c.addr_high       = pins[21:17];
    c.bus_data        = data;
    c.last            = last;
    return c;
  endfunction

  // Work out the bus cycles that one request calls for and queue them.
  task automatic expand_request(input req_item_t r);
    logic [PIN_ADDR_W-1:0] pins;
    logic                  in_range;
    pins = r.address[PIN_ADDR_W-1:0];
    case (r.cmd)
      CMD_READ: begin
        if (32'(r.address) >= 32'(DEFAULT_ACCESS_LIMIT)) begin
          expected_cycles.push_back(bus_cycle(KIND_REJECT, '0, 8'h00, 1'b1));
          rejects_seen <= rejects_seen + 1;
        end else begin
          expected_cycles.push_back(bus_cycle(KIND_READ, pins, 8'h00, 1'b1));
        end
      end
      CMD_PROGRAM: begin
        in_range = (32'(r.address) < 32'(DEFAULT_PROGRAM_LIMIT)) &&
                   (32'(r.address) < 32'(DEFAULT_ACCESS_LIMIT));
        if (!in_range) begin
          expected_cycles.push_back(bus_cycle(KIND_REJECT, '0, 8'h00, 1'b1));
          rejects_seen <= rejects_seen + 1;
        end else begin
          expected_cycles.push_back(bus_cycle(KIND_WRITE, UNLOCK_ADDR_A, UNLOCK_DATA_A, 1'b0));
          expected_cycles.push_back(bus_cycle(KIND_WRITE, UNLOCK_ADDR_B, UNLOCK_DATA_B, 1'b0));
          expected_cycles.push_back(bus_cycle(KIND_WRITE, UNLOCK_ADDR_A, PROGRAM_CODE, 1'b0));
          expected_cycles.push_back(bus_cycle(KIND_WRITE, pins, r.data_byte, 1'b1));
        end
      end
      CMD_ERASE: begin
        expected_cycles.push_back(bus_cycle(KIND_WRITE, UNLOCK_ADDR_A, UNLOCK_DATA_A, 1'b0));
        expected_cycles.push_back(bus_cycle(KIND_WRITE, UNLOCK_ADDR_B, UNLOCK_DATA_B, 1'b0));
        expected_cycles.push_back(bus_cycle(KIND_WRITE, UNLOCK_ADDR_A, ERASE_SETUP, 1'b0));
        expected_cycles.push_back(bus_cycle(KIND_WRITE, UNLOCK_ADDR_A, UNLOCK_DATA_A, 1'b0));
        expected_cycles.push_back(bus_cycle(KIND_WRITE, UNLOCK_ADDR_B, UNLOCK_DATA_B, 1'b0));
        expected_cycles.push_back(bus_cycle(KIND_WRITE, UNLOCK_ADDR_A, ERASE_CHIP, 1'b1));
      end
      default: begin
        expected_cycles.push_back(bus_cycle(KIND_RESET, '0, 8'h00, 1'b1));
      end
    endcase
  endtask

  // Report one field that differs from its prediction.
  function automatic int field_mismatch(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  // Compare a popped bus cycle with its prediction, field by field.
  function automatic int compare_cycle(res_item_t want, res_item_t got);
    int errs;
    errs = field_mismatch("cycle_kind", 8'(want.cycle_kind), 8'(got.cycle_kind));
    errs += field_mismatch("addr_bit_minus1", 8'(want.addr_bit_minus1),
                           8'(got.addr_bit_minus1));
    errs += field_mismatch("addr_low", want.addr_low, got.addr_low);
    errs += field_mismatch("addr_mid", want.addr_mid, got.addr_mid);
    errs += field_mismatch("addr_high", 8'(want.addr_high), 8'(got.addr_high));
    errs += field_mismatch("bus_data", want.bus_data, got.bus_data);
    errs += field_mismatch("last", 8'(want.last), 8'(got.last));
    return errs;
  endfunction

  // Watch both channels: predict on each request transaction and check on each result.
  always @(posedge clk) begin : watch_channels
    res_item_t want;
    int        errs;
    errs = 0;
    if (rst) begin
      expected_cycles.delete();
      fail_count     <= 0;
      outstanding    <= 0;
      requests_seen  <= 0;
      rejects_seen   <= 0;
      cycles_checked <= 0;
    end else begin
      if (push && !full) begin
        expand_request(req);
        requests_seen <= requests_seen + 1;
      end
      if (pop && !empty) begin
        if (expected_cycles.size() == 0) begin
          $error("result transaction with no bus cycle expected: 0x%0h", result);
          errs = 1;
        end else begin
          want = expected_cycles.pop_front();
          errs = compare_cycle(want, result);
        end
        cycles_checked <= cycles_checked + 1;
      end
      fail_count  <= fail_count + errs;
      outstanding <= expected_cycles.size();
    end
  end

endmodule

// ===== tb/nor_flash_command_sequencer_test.sv =====
// Top of the NOR flash command sequencer testbench: clock, reset, request and result traffic.
// Depends on nfcs_pkg, nor_flash_command_sequencer and nfcs_bus_checker.
`timescale 1ns / 1ps

module nor_flash_command_sequencer_test;
  import nfcs_pkg::*;

  localparam int RANDOM_REQUESTS = 500;
  localparam int BACK_TO_BACK    = 40;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int IDLE_LIMIT      = 3000;
  localparam int DRAIN_CYCLES    = 20;
  localparam int DIRECTED_COUNT  = 17;

  typedef enum logic [1:0] {
    DRAIN_FREE, DRAIN_COIN, DRAIN_TWO_OF_THREE, DRAIN_SPARSE
  } drain_mode_e;

  logic      clk  = 1'b0;
  logic      rst  = 1'b1;
  logic      push = 1'b0;
  logic      pop  = 1'b0;
  req_item_t req  = '0;
  logic      full;
  logic      empty;
  res_item_t result;
  logic      hold_request = 1'b0;

  int fail_count;
  int outstanding;
  int requests_seen;
  int rejects_seen;
  int cycles_checked;

  // Receiver state, owned by the result process alone.
  int          hold_left = 0;
  bit          hold_used = 1'b0;
  int          mode_left = 0;
  int          phase     = 0;
  drain_mode_e mode      = DRAIN_FREE;

  // Extremes of every field, every request, the range limits and the ignored fields.
  req_item_t directed [0:DIRECTED_COUNT-1] = '{
    '{CMD_READ,    26'h0000000, 8'h00},
    '{CMD_READ,    26'h3FFFFFF, 8'hFF},
    '{CMD_READ,    26'h2AAAAAA, 8'h55},
    '{CMD_READ,    26'h1555555, 8'hAA},
    '{CMD_READ,    26'h0000001, 8'h00},
    '{CMD_READ,    26'h3C00000, 8'h00},
    '{CMD_PROGRAM, 26'h0000000, 8'h00},
    '{CMD_PROGRAM, 26'h03FFFFF, 8'hFF},
    '{CMD_PROGRAM, 26'h0400000, 8'h5A},
    '{CMD_PROGRAM, 26'h3FFFFFF, 8'hA5},
    '{CMD_PROGRAM, 26'h02AAAAA, 8'h55},
    '{CMD_PROGRAM, 26'h0155555, 8'hAA},
    '{CMD_PROGRAM, 26'h2000000, 8'h12},
    '{CMD_ERASE,   26'h0000000, 8'h00},
    '{CMD_ERASE,   26'h3FFFFFF, 8'hFF},
    '{CMD_RESET,   26'h0000000, 8'h00},
    '{CMD_RESET,   26'h3FFFFFF, 8'hFF}
  };

  nor_flash_command_sequencer u_dut (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .req    (req),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  nfcs_bus_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .req            (req),
    .empty          (empty),
    .pop            (pop),
    .result         (result),
    .fail_count     (fail_count),
    .outstanding    (outstanding),
    .requests_seen  (requests_seen),
    .rejects_seen   (rejects_seen),
    .cycles_checked (cycles_checked)
  );

  // 12 ns clock.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Offer one request and hold it until the block takes the transaction.
  task automatic send_request(input req_item_t r);
    push <= 1'b1;
    req  <= r;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  // Leave the request channel idle; only called with a non-zero count.
  task automatic idle_sender(input int cycles);
    push <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Stop sending until every predicted bus cycle has been popped.
  task automatic drain_results();
    push <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Random request: programs mostly inside the programmable range, some near its limit.
  function automatic req_item_t make_request();
    req_item_t r;
    int        pick;
    int        spot;
    pick        = $urandom_range(0, 99);
    spot        = $urandom_range(0, 9);
    r.address   = 26'($urandom);
    r.data_byte = 8'($urandom);
    if (pick < 25) begin
      r.cmd = CMD_READ;
    end else if (pick < 65) begin
      r.cmd = CMD_PROGRAM;
      if (spot == 0) begin
        r.address = 26'(DEFAULT_PROGRAM_LIMIT - 4 + $urandom_range(0, 7));
      end else if (spot > 1) begin
        r.address = 26'($urandom_range(0, DEFAULT_PROGRAM_LIMIT - 1));
      end
    end else if (pick < 82) begin
      r.cmd = CMD_ERASE;
    end else begin
      r.cmd = CMD_RESET;
    end
    return r;
  endfunction

  // Result side: one long hold-off when asked, otherwise a changing stall pattern.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      pop <= 1'b0;
    end else if (hold_request && !hold_used) begin
      hold_used = 1'b1;
      hold_left = HOLD_OFF_CYCLES;
      pop <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        mode      = drain_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 80);
      end
      mode_left = mode_left - 1;
      phase     = phase + 1;
      case (mode)
        DRAIN_FREE:         pop <= 1'b1;
        DRAIN_COIN:         pop <= ($urandom_range(0, 1) == 1);
        DRAIN_TWO_OF_THREE: pop <= (phase % 3 != 0);
        default:            pop <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Watchdog: end the run if no transaction moves on either channel for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (push && !full) || (pop && !empty)) begin
        quiet = 0;
      end else begin
        quiet = quiet + 1;
      end
    end
    $error("no transaction for %0d cycles", IDLE_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  // Request side: directed requests, then random bursts, then the verdict.
  initial begin : stimulus
    int burst_left;
    int gap;
    burst_left = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed requests back to back, then let the block empty completely.
    for (int i = 0; i < DIRECTED_COUNT; i++) begin
      send_request(directed[i]);
    end
    drain_results();

    // Random requests; the first ones go back to back while the receiver holds off.
    hold_request <= 1'b1;
    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      send_request(make_request());
      if (i == RANDOM_REQUESTS / 2) begin
        drain_results();
      end else if (i >= BACK_TO_BACK) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 12);
          gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          if (gap > 0) idle_sender(gap);
        end
        burst_left = burst_left - 1;
      end
    end

    // Wait for the last bus cycles and give stray results time to show.
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d requests (%0d out of range) and checked %0d bus cycles,",
             requests_seen, rejects_seen, cycles_checked);
    $display("including a long result stall with the input full and two complete drains.");
    if (fail_count == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
